>>> rtl/tile_gid_draw_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Tile GID draw decoder assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TILE_GID_DRAW_DECODER_CORE_MACROS_SVH
`define TILE_GID_DRAW_DECODER_CORE_MACROS_SVH

// holds at every edge while reset is asserted
`define TGD_ASSERT_RESET(label, cond) \
    label: assert property (@(posedge clk) !rst_n |-> (cond)) \
        else $error("tgd: reset check failed");

// antecedent this cycle implies consequent next cycle
`define TGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgd: sequence check failed");

`endif

>>> rtl/tgd_pkg.sv
// ----------------------------------------------------------------------------
// Tile GID draw decoder package
// Widths, register codes and the types passed between the decoder modules.
// ----------------------------------------------------------------------------
package tgd_pkg;

    localparam int MAP_WIDTH    = 256;
    localparam int MAP_HEIGHT   = 256;
    localparam int NUM_TILESETS = 4;
    localparam int ID_BITS      = 16;

    localparam int ENTRY_ID_W  = 16;
    localparam int ID_W        = (ID_BITS < ENTRY_ID_W) ? ID_BITS : ENTRY_ID_W;
    localparam int GID_W       = 32;
    localparam int GID_ID_W    = 29;
    localparam int FLIP_H_BIT  = 31;
    localparam int FLIP_V_BIT  = 30;
    localparam int COLS_W      = 8;
    localparam int TW_W        = 8;
    localparam int CAM_W       = 24;
    localparam int POS_W       = 25;
    localparam int FRAC_BITS   = 4;
    localparam int COORD_W     = 8;
    localparam int PROD_W      = COORD_W + TW_W;
    localparam int ROW_W       = 16;
    localparam int IDX_W       = 2;
    localparam int TS_CNT_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 40;
    localparam int DIV_STAGES  = ID_W;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [TW_W-1:0] TILE_WIDTH_RESET = TW_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY_0,
        REG_ENTRY_1,
        REG_ENTRY_2,
        REG_ENTRY_3,
        REG_COUNT,
        REG_TILE_WIDTH,
        REG_CAMERA_X,
        REG_CAMERA_Y
    } cfg_reg_t;

    typedef struct packed {
        logic [ID_W-1:0]   first_id;
        logic [ID_W-1:0]   last_id;
        logic [COLS_W-1:0] columns;
    } tileset_t;

    typedef struct packed {
        tileset_t [NUM_TILESETS-1:0] entry;
        logic [TS_CNT_W-1:0]         count;
        logic [TW_W-1:0]             tile_width;
        logic [CAM_W-1:0]            camera_x;
        logic [CAM_W-1:0]            camera_y;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]   tileset_index;
        logic [ID_W-1:0]    local_id;
        logic [COLS_W-1:0]  columns;
        logic [COORD_W-1:0] map_column;
        logic [COORD_W-1:0] map_row;
        logic               flip_h;
        logic               flip_v;
    } item_t;

endpackage

>>> rtl/tgd_front.sv
// ----------------------------------------------------------------------------
// Tile GID draw decoder front end
// Accepts map words, finds the tileset and queues the draws; drops the rest.
// ----------------------------------------------------------------------------
module tgd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tgd_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [tgd_pkg::GID_W-1:0]  raw_gid,
    input  logic [tgd_pkg::COORD_W-1:0] map_column,
    input  logic [tgd_pkg::COORD_W-1:0] map_row,
    output logic                       push,
    output tgd_pkg::item_t             push_item,
    input  logic                       fifo_full
);
    import tgd_pkg::*;

    logic [GID_ID_W-1:0] gid_id;
    logic                found;
    logic [IDX_W-1:0]    sel_idx;
    logic [ID_W-1:0]     sel_first;
    logic [COLS_W-1:0]   sel_cols;
    logic                in_map;
    logic                draw;
    logic                take;
    logic                hold_valid_reg;
    logic                hold_valid_next;
    item_t               hold_item_reg;
    item_t               new_item;

    assign gid_id = raw_gid[GID_ID_W-1:0];

    // lowest enabled matching entry wins
    always_comb
    begin
        found     = 1'b0;
        sel_idx   = '0;
        sel_first = '0;
        sel_cols  = '0;
        for (int i = NUM_TILESETS - 1; i >= 0; i--)
        begin
            if ((TS_CNT_W'(i) < cfg.count)
                && (gid_id >= GID_ID_W'(cfg.entry[i].first_id))
                && (gid_id <= GID_ID_W'(cfg.entry[i].last_id)))
            begin
                found     = 1'b1;
                sel_idx   = IDX_W'(i);
                sel_first = cfg.entry[i].first_id;
                sel_cols  = cfg.entry[i].columns;
            end
        end
    end

    assign in_map = (32'(map_column) < MAP_WIDTH) && (32'(map_row) < MAP_HEIGHT);
    assign draw   = (gid_id != '0) && in_map && found && (sel_cols != '0);

    always_comb
    begin
        new_item.tileset_index = sel_idx;
        new_item.local_id      = ID_W'(gid_id - GID_ID_W'(sel_first));
        new_item.columns       = sel_cols;
        new_item.map_column    = map_column;
        new_item.map_row       = map_row;
        new_item.flip_h        = raw_gid[FLIP_H_BIT];
        new_item.flip_v        = raw_gid[FLIP_V_BIT];
    end

    assign push      = hold_valid_reg && !fifo_full;
    assign in_stall  = hold_valid_reg && fifo_full;
    assign take      = in_valid && !in_stall;
    assign push_item = hold_item_reg;

    assign hold_valid_next = take ? draw : (hold_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && draw)
        begin
            hold_item_reg <= new_item;
        end
    end

endmodule

>>> rtl/tgd_fifo.sv
// ----------------------------------------------------------------------------
// Tile GID draw decoder queue
// Short first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
module tgd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tgd_pkg::item_t wr_item,
    output logic           full,
    input  logic           pop,
    output tgd_pkg::item_t rd_item,
    output logic           empty
);
    import tgd_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign full    = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> rtl/tgd_back.sv
// ----------------------------------------------------------------------------
// Tile GID draw decoder back end
// Pipelined long division of the local id and screen position arithmetic,
// one quotient bit per stage, ending in the output register.
// ----------------------------------------------------------------------------
module tgd_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tgd_pkg::cfg_t                    cfg,
    input  logic                             empty,
    output logic                             pop,
    input  tgd_pkg::item_t                   head,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tgd_pkg::IDX_W-1:0]        tileset_index,
    output logic [tgd_pkg::ROW_W-1:0]        source_row,
    output logic [tgd_pkg::COLS_W-1:0]       source_column,
    output logic signed [tgd_pkg::POS_W-1:0] screen_x,
    output logic signed [tgd_pkg::POS_W-1:0] screen_y,
    output logic                             flip_horizontal,
    output logic                             flip_vertical
);
    import tgd_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [ID_W-1:0]   work;
        logic [COLS_W-1:0] rem;
        logic [COLS_W-1:0] divisor;
        logic [PROD_W-1:0] prod_x;
        logic [PROD_W-1:0] prod_y;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic              flip_h;
        logic              flip_v;
    } stage_t;

    // one restoring division step: shift in the next dividend bit
    function automatic stage_t div_step(stage_t s);
        logic [COLS_W:0] trial;
        stage_t          r;
        r     = s;
        trial = {s.rem, s.work[ID_W-1]};
        if (trial >= {1'b0, s.divisor})
        begin
            r.rem  = COLS_W'(trial - {1'b0, s.divisor});
            r.work = {s.work[ID_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = trial[COLS_W-1:0];
            r.work = {s.work[ID_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] place(logic [PROD_W-1:0] prod,
                                               logic [CAM_W-1:0] cam);
        return POS_W'({prod, {FRAC_BITS{1'b0}}})
             - {{(POS_W - CAM_W){cam[CAM_W-1]}}, cam};
    endfunction

    stage_t                st_reg  [DIV_STAGES+1];
    stage_t                st_next [DIV_STAGES+1];
    stage_t                head_stage;
    stage_t                first_step;
    logic [DIV_STAGES:0]   st_valid_reg;
    logic [DIV_STAGES:0]   st_valid_next;
    logic                  adv;
    logic                  out_valid_reg;

    assign adv = !(out_valid_reg && out_stall);
    assign pop = adv && !empty;

    always_comb
    begin
        head_stage.idx     = head.tileset_index;
        head_stage.work    = head.local_id;
        head_stage.rem     = '0;
        head_stage.divisor = head.columns;
        head_stage.prod_x  = PROD_W'(head.map_column) * PROD_W'(cfg.tile_width);
        head_stage.prod_y  = PROD_W'(head.map_row) * PROD_W'(cfg.tile_width);
        head_stage.pos_x   = '0;
        head_stage.pos_y   = '0;
        head_stage.flip_h  = head.flip_h;
        head_stage.flip_v  = head.flip_v;
    end

    always_comb
    begin
        first_step       = div_step(st_reg[0]);
        first_step.pos_x = place(st_reg[0].prod_x, cfg.camera_x);
        first_step.pos_y = place(st_reg[0].prod_y, cfg.camera_y);
    end

    assign st_next[0]    = head_stage;
    assign st_next[1]    = first_step;
    assign st_valid_next = {st_valid_reg[DIV_STAGES-1:0], pop};

    for (genvar k = 2; k <= DIV_STAGES; k++)
    begin : g_step
        assign st_next[k] = div_step(st_reg[k-1]);
    end

    for (genvar k = 0; k <= DIV_STAGES; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= st_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tileset_index   <= st_reg[DIV_STAGES].idx;
            source_row      <= ROW_W'(st_reg[DIV_STAGES].work);
            source_column   <= st_reg[DIV_STAGES].rem;
            screen_x        <= st_reg[DIV_STAGES].pos_x;
            screen_y        <= st_reg[DIV_STAGES].pos_y;
            flip_horizontal <= st_reg[DIV_STAGES].flip_h;
            flip_vertical   <= st_reg[DIV_STAGES].flip_v;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/tile_gid_draw_decoder_core.sv
// ----------------------------------------------------------------------------
// Tile GID draw decoder core
// Decodes one tile map word per beat into a tileset draw command.
// ----------------------------------------------------------------------------
// Input beat: raw_gid, map_column, map_row, taken when in_valid is high and
// in_stall low. Words with id zero, off-map positions, no matching tileset or
// a matched tileset with zero columns are taken and produce no output beat.
// Output beat: tileset_index, source_row/column, screen_x/y, flips, taken when
// out_valid is high and out_stall low.
// The id split runs through a 16-stage long divider, one quotient bit per stage.
// Throughput: one beat per cycle unless out_stall holds the pipeline.
// A four-entry queue separates the classifier from the divider pipeline, so
// in_stall rises only after out_stall has held the whole pipeline for a while;
// any cycle without out_stall releases it again.
// Configuration: cfg_write with cfg_index and cfg_data, only while idle.
// Reset clears all beats in flight and sets the registers to their defaults
// (no tilesets, tile width 16, camera at zero).
// ----------------------------------------------------------------------------
module tile_gid_draw_decoder_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tgd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tgd_pkg::GID_W-1:0]        raw_gid,
    input  logic [tgd_pkg::COORD_W-1:0]      map_column,
    input  logic [tgd_pkg::COORD_W-1:0]      map_row,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tgd_pkg::IDX_W-1:0]        tileset_index,
    output logic [tgd_pkg::ROW_W-1:0]        source_row,
    output logic [tgd_pkg::COLS_W-1:0]       source_column,
    output logic signed [tgd_pkg::POS_W-1:0] screen_x,
    output logic signed [tgd_pkg::POS_W-1:0] screen_y,
    output logic                             flip_horizontal,
    output logic                             flip_vertical
);
    import tgd_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push;
    item_t push_item;
    logic  fifo_full;
    logic  fifo_empty;
    logic  pop;
    item_t head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            for (int i = 0; i < NUM_TILESETS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_ENTRY_0) + CFG_IDX_W'(i))
                begin
                    cfg_next.entry[i].first_id = ID_W'(cfg_data[ENTRY_ID_W-1:0]);
                    cfg_next.entry[i].last_id  =
                        ID_W'(cfg_data[2*ENTRY_ID_W-1:ENTRY_ID_W]);
                    cfg_next.entry[i].columns  =
                        cfg_data[2*ENTRY_ID_W+COLS_W-1:2*ENTRY_ID_W];
                end
            end
            case (cfg_reg_t'(cfg_index))
                REG_COUNT:      cfg_next.count      = cfg_data[TS_CNT_W-1:0];
                REG_TILE_WIDTH: cfg_next.tile_width = cfg_data[TW_W-1:0];
                REG_CAMERA_X:   cfg_next.camera_x   = cfg_data[CAM_W-1:0];
                REG_CAMERA_Y:   cfg_next.camera_y   = cfg_data[CAM_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{entry: '0, count: '0, tile_width: TILE_WIDTH_RESET,
                         camera_x: '0, camera_y: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tgd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_gid    (raw_gid),
        .map_column (map_column),
        .map_row    (map_row),
        .push       (push),
        .push_item  (push_item),
        .fifo_full  (fifo_full)
    );

    tgd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (push_item),
        .full    (fifo_full),
        .pop     (pop),
        .rd_item (head),
        .empty   (fifo_empty)
    );

    tgd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .empty           (fifo_empty),
        .pop             (pop),
        .head            (head),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tileset_index   (tileset_index),
        .source_row      (source_row),
        .source_column   (source_column),
        .screen_x        (screen_x),
        .screen_y        (screen_y),
        .flip_horizontal (flip_horizontal),
        .flip_vertical   (flip_vertical)
    );

endmodule

>>> rtl/tgd_checker.sv
// ----------------------------------------------------------------------------
// Tile GID draw decoder port checker
// Port-level checks on reset, stall release and output hold, bound to the core.
// ----------------------------------------------------------------------------
`include "tile_gid_draw_decoder_core_macros.svh"

module tgd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [tgd_pkg::IDX_W-1:0]        tileset_index,
    input logic [tgd_pkg::ROW_W-1:0]        source_row,
    input logic [tgd_pkg::COLS_W-1:0]       source_column,
    input logic signed [tgd_pkg::POS_W-1:0] screen_x,
    input logic signed [tgd_pkg::POS_W-1:0] screen_y,
    input logic                             flip_horizontal,
    input logic                             flip_vertical
);
    import tgd_pkg::*;

    logic [IDX_W+ROW_W+COLS_W+2*POS_W+1:0] out_beat;

    assign out_beat = {tileset_index, source_row, source_column, screen_x, screen_y,
                       flip_horizontal, flip_vertical};

    // nothing in flight while reset is held
    `TGD_ASSERT_RESET(a_reset_idle, !out_valid && !in_stall)

    // an unstalled output cycle drains a queue slot, so input is free next
    `TGD_ASSERT_NEXT(a_stall_release, !out_stall, !in_stall)

    // stalled output beat holds
    `TGD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))

endmodule

bind tile_gid_draw_decoder_core tgd_checker u_tgd_checker (.*);
